>>> src/pidci_pkg.sv
// ----------------------------------------------------------------------------
// pidci_pkg: shared types and constants
// Holds the fixed-point widths, the function codes, the register map and the sequencer states of
// the PID controller with conditional integration.
// ----------------------------------------------------------------------------
package pidci_pkg;

  localparam int DataW   = 32;
  localparam int FracW   = 16;
  localparam int StepW   = 16;
  localparam int BoundW  = 31;
  localparam int ProdW   = 2 * DataW;
  localparam int TermW   = ProdW - FracW;
  localparam int AccW    = TermW + 2;
  localparam int DivW    = DataW + 1 + StepW;
  localparam int AddrW   = 5;

  typedef enum logic [1:0] {
    FUNC_ERR_DERIV = 2'd0,
    FUNC_RATE      = 2'd1,
    FUNC_CLEAR     = 2'd2,
    FUNC_NONE      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_BOUND = 3'd3,
    REG_OUT_BOUND   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DT,
    ST_CAND,
    ST_ACC_P,
    ST_ACC_I,
    ST_DIV,
    ST_DSAT,
    ST_MUL_D,
    ST_ACC_D,
    ST_ACC_DN,
    ST_FINAL
  } state_t;

endpackage

>>> src/pidci_div.sv
// ----------------------------------------------------------------------------
// pidci_div: bit-serial restoring divider
// Divides an unsigned dividend by a nonzero 16-bit divisor, one quotient bit
// per cycle; busy drops when the quotient is complete.
// ----------------------------------------------------------------------------
module pidci_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pidci_pkg::DivW-1:0]    dividend,
  input  logic [pidci_pkg::StepW-1:0]   divisor,
  output logic                          busy,
  output logic [pidci_pkg::DivW-1:0]    quotient
);
  import pidci_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [CntW-1:0]  cnt;
  logic [StepW-1:0] rem;
  logic [StepW:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[DivW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(DivW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? StepW'(trial - {1'b0, divisor}) : trial[StepW-1:0];
      quotient <= {quotient[DivW-2:0], ge};
    end
  end

endmodule

>>> src/pid_controller_conditional_integration_core.sv
// ----------------------------------------------------------------------------
// pid_controller_conditional_integration_core: PID with clamped integrator
// Computes a clamped PID drive per sample, keeping the integral only when the
// output is unsaturated or the error pulls it back out of saturation.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_*       in         tuser: func; tdata: err_sample, rate_sample, step_time
// m_*       out        tdata: drive
// APB       in/out     prop_gain, integ_gain, deriv_gain, integ_bound, out_bound
//
// In measured-rate mode a transaction runs through the multiply, candidate,
// proportional, integral and negative-derivative steps. In error-derivative
// mode it ends after the integral step without a previous sample and else
// also waits for the bit-serial divider, which produces its 49 quotient bits
// one per cycle. A clear, an unused selector or a zero time step goes
// straight to the final step. All products go through one shared 32x32
// multiplier with a registered result. The input is not ready while a
// transaction is being processed; a finished result waits in the output
// register, and the last step stalls only if that register is still full.
// Reset clears the configuration registers, output valid, integrator, last error and primed bit.
module pid_controller_conditional_integration_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] err_sample, [63:32] rate_sample, [79:64] step_time
  input  logic [79:0]                    s_tdata,
  // [1:0] func
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] drive
  output logic [31:0]                    m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pidci_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pidci_pkg::*;

  // Configuration registers.
  logic signed [DataW-1:0] prop_gain, integ_gain, deriv_gain;
  logic [BoundW-1:0]       integ_bound, out_bound;
  reg_idx_t                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_bound <= '0;
      out_bound   <= '0;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_PROP_GAIN:   prop_gain   <= pwdata;
        REG_INTEG_GAIN:  integ_gain  <= pwdata;
        REG_DERIV_GAIN:  deriv_gain  <= pwdata;
        REG_INTEG_BOUND: integ_bound <= pwdata[BoundW-1:0];
        REG_OUT_BOUND:   out_bound   <= pwdata[BoundW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:   prdata = prop_gain;
      REG_INTEG_GAIN:  prdata = integ_gain;
      REG_DERIV_GAIN:  prdata = deriv_gain;
      REG_INTEG_BOUND: prdata = {1'b0, integ_bound};
      REG_OUT_BOUND:   prdata = {1'b0, out_bound};
      default:         prdata = '0;
    endcase
  end

  // Controller state.
  logic signed [DataW-1:0] integ_acc, last_err;
  logic                    primed;

  // Latched transaction.
  func_t                   func;
  logic signed [DataW-1:0] err, rate;
  logic [StepW-1:0]        dt;

  // Datapath registers.
  state_t                  state, state_next;
  logic signed [ProdW-1:0] prod;
  logic signed [DataW-1:0] mul_a, mul_b;
  logic signed [DataW-1:0] cand, deriv;
  logic signed [AccW-1:0]  acc;
  logic                    dneg;

  // Divider.
  logic                    div_start, div_busy;
  logic [DivW-1:0]         div_q;
  logic signed [DataW:0]   diff;
  logic [DataW:0]          diff_mag;

  assign diff     = {err[DataW-1], err} - {last_err[DataW-1], last_err};
  assign diff_mag = diff[DataW] ? (DataW+1)'(-diff) : diff;

  pidci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_mag, {StepW{1'b0}}}),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Product scaled back to Q32.16, floor rounding, sign-extended to the sum.
  logic signed [TermW-1:0] term;
  assign term = prod[ProdW-1:FracW];

  // Candidate integral, clamped to the integral bound.
  logic signed [DataW+1:0] cand_sum;
  logic signed [DataW+1:0] ib_pos;
  logic signed [DataW-1:0] cand_clamped;
  assign cand_sum = (DataW+2)'(integ_acc) + (DataW+2)'(prod[DataW+FracW+1:FracW]);
  assign ib_pos   = (DataW+2)'({1'b0, integ_bound});
  always_comb begin
    if (cand_sum > ib_pos) begin
      cand_clamped = DataW'(ib_pos);
    end else if (cand_sum < -ib_pos) begin
      cand_clamped = DataW'(-ib_pos);
    end else begin
      cand_clamped = DataW'(cand_sum);
    end
  end

  // Derivative saturation of the divider's quotient.
  localparam logic [DivW-1:0] DerivLim = DivW'(1) << (DataW - 1);
  logic [DataW-1:0] dmag;
  assign dmag = (div_q >= DerivLim) ? DataW'(DerivLim) : div_q[DataW-1:0];

  // Final drive compare and clamp.
  logic signed [AccW-1:0] ob_pos;
  logic                   above, below, keep;
  logic signed [DataW-1:0] drive_val;
  assign ob_pos = AccW'({1'b0, out_bound});
  assign above  = acc > ob_pos;
  assign below  = acc < -ob_pos;
  assign keep   = (!above && !below) || (above && err < 0) || (below && err > 0);
  assign drive_val = above ? DataW'(ob_pos) : below ? DataW'(-ob_pos) : DataW'(acc);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Sequencer: picks multiplier operands, starts the divider and picks the next step.
  always_comb begin
    state_next = state;
    mul_a      = err;
    mul_b      = err;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (func_t'(s_tuser) == FUNC_ERR_DERIV || func_t'(s_tuser) == FUNC_RATE) begin
            state_next = (s_tdata[79:64] == '0) ? ST_FINAL : ST_MUL_DT;
          end else begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_MUL_DT: begin
        mul_a      = err;
        mul_b      = DataW'({1'b0, dt});
        state_next = ST_CAND;
      end
      ST_CAND: begin
        mul_a      = prop_gain;
        mul_b      = err;
        state_next = ST_ACC_P;
      end
      ST_ACC_P: begin
        mul_a      = integ_gain;
        mul_b      = cand;
        state_next = ST_ACC_I;
      end
      ST_ACC_I: begin
        mul_a = deriv_gain;
        mul_b = rate;
        if (func == FUNC_RATE) begin
          state_next = ST_ACC_DN;
        end else if (primed) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_DSAT;
        end
      end
      ST_DSAT: state_next = ST_MUL_D;
      ST_MUL_D: begin
        mul_a      = deriv_gain;
        mul_b      = deriv;
        state_next = ST_ACC_D;
      end
      ST_ACC_D:  state_next = ST_FINAL;
      ST_ACC_DN: state_next = ST_FINAL;
      ST_FINAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Datapath updates.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          func <= func_t'(s_tuser);
          err  <= s_tdata[31:0];
          rate <= s_tdata[63:32];
          dt   <= s_tdata[79:64];
          acc  <= '0;
        end
      end
      ST_CAND:  cand <= cand_clamped;
      ST_ACC_P: acc  <= AccW'(term);
      ST_ACC_I: begin
        acc  <= acc + AccW'(term);
        dneg <= diff[DataW];
      end
      ST_DSAT: begin
        if (dneg) begin
          deriv <= DataW'(-{1'b0, dmag});
        end else if (dmag == DataW'(DerivLim)) begin
          deriv <= DataW'(DerivLim - 1'b1);
        end else begin
          deriv <= dmag;
        end
      end
      ST_ACC_D:  acc <= acc + AccW'(term);
      ST_ACC_DN: acc <= acc - AccW'(term);
      default: ;
    endcase
  end

  // Controller state: cleared by a clear transaction, updated on a valid step.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      last_err  <= '0;
      primed    <= 1'b0;
    end else if (state == ST_FINAL && out_free) begin
      if (func == FUNC_CLEAR) begin
        integ_acc <= '0;
        last_err  <= '0;
        primed    <= 1'b0;
      end else if ((func == FUNC_ERR_DERIV || func == FUNC_RATE) && dt != '0) begin
        if (keep) begin
          integ_acc <= cand;
        end
        last_err <= err;
        primed   <= 1'b1;
      end
    end
  end

  // Output register: a clear, unused selector or zero step yields zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINAL && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINAL && out_free) begin
      if ((func == FUNC_ERR_DERIV || func == FUNC_RATE) && dt != '0) begin
        m_tdata <= drive_val;
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule
